// ===== hdl/length_prefixed_frame_parser_core_macros.svh =====
`ifndef LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_CORE_MACROS_SVH

// check a property outside reset
`define LPFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define LPFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/lpfp_pkg.sv =====
package lpfp_pkg;

    localparam logic       OP_DATA  = 1'b0;
    localparam logic       OP_CLEAR = 1'b1;

    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_TYPE = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_TYPE_MIN    = 2'd1;
    localparam logic [1:0] CFG_TYPE_MAX    = 2'd2;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;
    localparam logic [15:0] TYPE_MIN_RST    = 16'd0;
    localparam logic [15:0] TYPE_MAX_RST    = 16'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] msg_type;
        logic [15:0] method_id;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        frame_last;
    } t_out;

endpackage

// ===== hdl/length_prefixed_frame_parser_core.sv =====
// Results are registered in the output register, or the skid one while it is held.
// Throughput: one request per cycle unless stalled; parse state is a counter and shift.
// A two-entry output buffer keeps input flowing while one result waits downstream.
// Reset (synchronous, active low) clears the parser, the error flag and the output
// buffer, and returns the configuration registers to their defaults.
module length_prefixed_frame_parser_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lpfp_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lpfp_pkg::t_out     o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import lpfp_pkg::*;

    logic [31:0] r_max_payload;
    logic [15:0] r_type_min;
    logic [15:0] r_type_max;

    logic        r_failed, n_failed;
    logic        r_in_payload, n_in_payload;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [63:0] r_hdr_shift, n_hdr_shift;
    logic [31:0] r_bytes_left, n_bytes_left;

    logic        r_out_valid;
    t_out        r_out;
    logic        r_skid_valid;
    t_out        r_skid;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    t_out        res;
    logic [63:0] shift_in;
    logic [15:0] hdr_type;
    logic [31:0] hdr_len;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign shift_in = {r_hdr_shift[55:0], i_in.data_byte};
    assign hdr_type = shift_in[63:48];
    assign hdr_len  = shift_in[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_type_min    <= TYPE_MIN_RST;
            r_type_max    <= TYPE_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                CFG_TYPE_MIN:    r_type_min    <= i_cfg_data[15:0];
                CFG_TYPE_MAX:    r_type_max    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_failed     = r_failed;
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_hdr_shift  = r_hdr_shift;
        n_bytes_left = r_bytes_left;
        res_valid    = 1'b0;
        res.status         = ST_PAYLOAD;
        res.msg_type       = r_hdr_shift[63:48];
        res.method_id      = r_hdr_shift[47:32];
        res.payload_length = r_hdr_shift[31:0];
        res.payload_byte   = 8'd0;
        res.frame_last     = 1'b0;
        if (in_accept) begin
            if (i_in.op == OP_CLEAR) begin
                n_failed     = 1'b0;
                n_in_payload = 1'b0;
                n_hdr_cnt    = 3'd0;
                n_hdr_shift  = 64'd0;
                n_bytes_left = 32'd0;
            end else if (!r_failed) begin
                if (r_in_payload) begin
                    n_bytes_left     = r_bytes_left - 32'd1;
                    res_valid        = 1'b1;
                    res.payload_byte = i_in.data_byte;
                    res.frame_last   = (r_bytes_left == 32'd1);
                    if (r_bytes_left == 32'd1) begin
                        n_in_payload = 1'b0;
                        n_hdr_cnt    = 3'd0;
                    end
                end else begin
                    n_hdr_shift        = shift_in;
                    res.msg_type       = shift_in[63:48];
                    res.method_id      = shift_in[47:32];
                    res.payload_length = shift_in[31:0];
                    if (r_hdr_cnt != 3'd7) begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end else begin
                        n_hdr_cnt      = 3'd0;
                        res.frame_last = 1'b1;
                        if (hdr_type < r_type_min || hdr_type > r_type_max) begin
                            n_failed   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = ST_BAD_TYPE;
                        end else if (hdr_len > r_max_payload) begin
                            n_failed   = 1'b1;
                            res_valid  = 1'b1;
                            res.status = ST_OVERSIZE;
                        end else if (hdr_len == 32'd0) begin
                            res_valid  = 1'b1;
                            res.status = ST_EMPTY;
                        end else begin
                            n_in_payload = 1'b1;
                            n_bytes_left = hdr_len;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failed     <= 1'b0;
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= 3'd0;
            r_hdr_shift  <= 64'd0;
            r_bytes_left <= 32'd0;
        end else begin
            r_failed     <= n_failed;
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_hdr_shift  <= n_hdr_shift;
            r_bytes_left <= n_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

endmodule

// ===== hdl/lpfp_checker.sv =====
`include "length_prefixed_frame_parser_core_macros.svh"

module lpfp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_stall,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  lpfp_pkg::t_out     o_out
);
    import lpfp_pkg::*;

    logic out_idle;
    logic out_held;
    logic out_error;
    logic out_error_ok;
    logic out_empty;
    logic out_empty_ok;

    assign out_idle     = !o_out_valid && !o_in_stall;
    assign out_held     = o_out_valid && i_out_stall;
    assign out_error    = o_out_valid
                          && (o_out.status == ST_BAD_TYPE || o_out.status == ST_OVERSIZE);
    assign out_error_ok = o_out.frame_last && (o_out.payload_byte == 8'd0);
    assign out_empty    = o_out_valid && (o_out.status == ST_EMPTY);
    assign out_empty_ok = o_out.frame_last && (o_out.payload_length == 32'd0);

    `LPFP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> out_idle, "not empty after reset")
    `LPFP_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_out), "stalled result changed")
    `LPFP_ASSERT(a_stall_needs_result, o_in_stall |-> o_out_valid, "stall with no result")
    `LPFP_ASSERT(a_error_closes, out_error |-> out_error_ok, "error result malformed")
    `LPFP_ASSERT(a_empty_frame, out_empty |-> out_empty_ok, "empty frame result malformed")

endmodule

bind length_prefixed_frame_parser_core lpfp_checker u_lpfp_checker (.*);
